// ===== hdl/tofc_pkg.sv =====
// shared types, constants and the log mantissa table for the time-of-flight correction
package tofc_pkg;

  localparam int ARMS_DEF    = 2;
  localparam int SECTORS_DEF = 4;
  localparam int ROWS_DEF    = 48;
  localparam int COLUMNS_DEF = 96;

  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 10;
  localparam int BACK_STAGES = 7;

  localparam int Q_ONE  = 65536;
  localparam int Q_LN2  = 45426;
  localparam int Q_C091 = 59638;
  localparam int Q_C017 = 11141;

  typedef enum logic [1:0] {
    MODE_CORRECT      = 2'd0,
    MODE_TOWER_OFFSET = 2'd1,
    MODE_SECT_OFFSET  = 2'd2,
    MODE_SECT_GAIN    = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic               arm;
    logic [1:0]         sector;
    logic [5:0]         row;
    logic [6:0]         column;
    logic signed [31:0] raw_time;
    logic [31:0]        energy;
    logic signed [31:0] table_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] corrected_time;
    logic               index_error;
  } out_word_t;

  typedef struct packed {
    logic               index_error;
    logic signed [31:0] raw_time;
    logic [31:0]        energy;
    logic signed [31:0] sect_off;
    logic signed [31:0] sect_gain;
    logic signed [31:0] tower_off;
  } mid_word_t;

  // ln(1 + i/32) in unsigned q0.16
  localparam logic [15:0] LN_TAB [33] = '{
    16'd0,     16'd2017,  16'd3973,  16'd5873,  16'd7719,  16'd9515,  16'd11262, 16'd12965,
    16'd14624, 16'd16242, 16'd17821, 16'd19364, 16'd20870, 16'd22343, 16'd23783, 16'd25193,
    16'd26573, 16'd27924, 16'd29248, 16'd30546, 16'd31818, 16'd33067, 16'd34292, 16'd35494,
    16'd36675, 16'd37835, 16'd38975, 16'd40095, 16'd41196, 16'd42280, 16'd43345, 16'd44394,
    16'd45426
  };

endpackage

// ===== hdl/tofc_queue.sv =====
// small first-in first-out word queue
module tofc_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o,
  output logic                         empty_o,
  output logic                         full_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/tofc_front.sv =====
// front end: accepts words, applies table writes, looks up offsets and gain
module tofc_front #(
  parameter int ARMS      = tofc_pkg::ARMS_DEF,
  parameter int SECTORS   = tofc_pkg::SECTORS_DEF,
  parameter int ROWS      = tofc_pkg::ROWS_DEF,
  parameter int COLUMNS   = tofc_pkg::COLUMNS_DEF,
  parameter int MID_DEPTH = tofc_pkg::MID_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  tofc_pkg::in_word_t               in_word_i,
  input  logic [$clog2(MID_DEPTH+1)-1:0]   mid_cnt_i,
  output logic                             mid_push_o,
  output tofc_pkg::mid_word_t              mid_word_o
);
  localparam int SN   = ARMS * SECTORS;
  localparam int TN   = SN * ROWS * COLUMNS;
  localparam int SI_W = (SN > 1) ? $clog2(SN) : 1;
  localparam int TI_W = (TN > 1) ? $clog2(TN) : 1;

  logic signed [31:0] sect_off_q  [SN];
  logic signed [31:0] sect_gain_q [SN];
  logic signed [31:0] tower_mem   [TN];
  logic signed [31:0] tower_rd_q;

  logic            accept;
  logic            sect_ok, tower_ok;
  logic [SI_W-1:0] si;
  logic [TI_W-1:0] ti;

  logic               stage_v_q;
  logic               err_q;
  logic signed [31:0] raw_q, soff_q, sgain_q;
  logic [31:0]        energy_q;

  assign full   = (32'(mid_cnt_i) + 32'(stage_v_q)) >= 32'(MID_DEPTH);
  assign accept = push && !full;

  assign sect_ok  = (32'(in_word_i.arm) < 32'(ARMS)) && (32'(in_word_i.sector) < 32'(SECTORS));
  assign tower_ok = sect_ok && (32'(in_word_i.row) < 32'(ROWS))
                    && (32'(in_word_i.column) < 32'(COLUMNS));
  assign si = SI_W'(32'(in_word_i.arm) * SECTORS + 32'(in_word_i.sector));
  assign ti = TI_W'((32'(si) * ROWS + 32'(in_word_i.row)) * COLUMNS + 32'(in_word_i.column));

  // sector tables, reset to zero offset and unit gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SN; k++) begin
        sect_off_q[k]  <= '0;
        sect_gain_q[k] <= 32'(tofc_pkg::Q_ONE);
      end
    end else if (accept && sect_ok) begin
      if (in_word_i.mode == tofc_pkg::MODE_SECT_OFFSET) begin
        sect_off_q[si] <= in_word_i.table_value;
      end
      if (in_word_i.mode == tofc_pkg::MODE_SECT_GAIN) begin
        sect_gain_q[si] <= in_word_i.table_value;
      end
    end
  end

  // per-tower offset memory, registered read
  always_ff @(posedge clk_i) begin
    if (accept && tower_ok && in_word_i.mode == tofc_pkg::MODE_TOWER_OFFSET) begin
      tower_mem[ti] <= in_word_i.table_value;
    end
    if (accept) begin
      tower_rd_q <= tower_mem[ti];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= accept && (in_word_i.mode == tofc_pkg::MODE_CORRECT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q    <= !tower_ok;
      raw_q    <= in_word_i.raw_time;
      energy_q <= in_word_i.energy;
      soff_q   <= sect_off_q[si];
      sgain_q  <= sect_gain_q[si];
    end
  end

  assign mid_push_o = stage_v_q;
  always_comb begin
    mid_word_o.index_error = err_q;
    mid_word_o.raw_time    = raw_q;
    mid_word_o.energy      = energy_q;
    mid_word_o.sect_off    = soff_q;
    mid_word_o.sect_gain   = sgain_q;
    mid_word_o.tower_off   = tower_rd_q;
  end

endmodule

// ===== hdl/tofc_back.sv =====
// back end: arithmetic pipeline for the time and energy correction
module tofc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  tofc_pkg::mid_word_t        mid_word_i,
  input  logic signed [31:0]         mean_start_time_i,
  output logic                       out_valid_o,
  output tofc_pkg::out_word_t        out_word_o,
  output logic [$clog2(tofc_pkg::BACK_STAGES+1)-1:0] inflight_o
);
  localparam int NS = tofc_pkg::BACK_STAGES;

  logic [NS-1:0] v_q;
  logic [NS-1:0] err_q;
  logic [NS-1:0] en_q;

  // stage 1
  logic signed [33:0] d1_q;
  logic signed [31:0] h1_q;
  logic signed [32:0] hm1_q;
  logic [31:0]        e1_q;
  logic [3:0]         nz1_q;
  logic [2:0]         bpos1_q [4];
  logic [2:0]         bpos_d  [4];
  // stage 2
  logic signed [65:0] prod1_q;
  logic signed [64:0] prod2_q;
  logic [4:0]         p_d, p2_q;
  logic [30:0]        x2_q;
  // stage 3
  logic signed [49:0] a1_q [3:6];
  logic signed [48:0] a2_q [3:6];
  logic [3:0]         pm3_q;
  logic [15:0]        lnm3_q;
  logic [5:0]         i_lo, i_hi;
  logic [15:0]        diff;
  // stage 4 to 6
  logic [19:0]        s4_q;
  logic [23:0]        sq5_q;
  logic [20:0]        sh6_q;
  // stage 7
  logic signed [51:0] r_d;
  logic signed [31:0] res7_q;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bpos_d[b] = '0;
      for (int k = 0; k < 8; k++) begin
        if (mid_word_i.energy[8*b+k]) begin
          bpos_d[b] = 3'(k);
        end
      end
    end
  end

  always_comb begin
    priority if (nz1_q[3]) begin
      p_d = {2'd3, bpos1_q[3]};
    end else if (nz1_q[2]) begin
      p_d = {2'd2, bpos1_q[2]};
    end else if (nz1_q[1]) begin
      p_d = {2'd1, bpos1_q[1]};
    end else begin
      p_d = {2'd0, bpos1_q[0]};
    end
  end

  assign i_lo = {1'b0, x2_q[30:26]};
  assign i_hi = i_lo + 6'd1;
  assign diff = tofc_pkg::LN_TAB[i_hi] - tofc_pkg::LN_TAB[i_lo];

  always_comb begin
    r_d = 52'(a1_q[6]) - 52'(a2_q[6]) - 52'($signed({1'b0, sh6_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= {err_q[NS-2:0], mid_word_i.index_error};
    en_q  <= {en_q[NS-2:0], (mid_word_i.energy > 32'(tofc_pkg::Q_ONE))};

    d1_q  <= 34'(mid_word_i.raw_time) - 34'(mid_word_i.sect_off) - 34'(mid_word_i.tower_off);
    h1_q  <= mid_word_i.sect_gain;
    hm1_q <= 33'(mid_word_i.sect_gain) - 33'sd65536;
    e1_q  <= mid_word_i.energy;
    for (int b = 0; b < 4; b++) begin
      nz1_q[b]   <= |mid_word_i.energy[8*b +: 8];
      bpos1_q[b] <= bpos_d[b];
    end

    prod1_q <= h1_q * d1_q;
    prod2_q <= hm1_q * mean_start_time_i;
    p2_q    <= p_d;
    x2_q    <= 31'(e1_q << (5'd31 - p_d));

    a1_q[3] <= 50'((prod1_q + 66'sd32768) >>> 16);
    a2_q[3] <= 49'((prod2_q + 65'sd32768) >>> 16);
    pm3_q   <= 4'(p2_q - 5'd16);
    lnm3_q  <= tofc_pkg::LN_TAB[i_lo] + 16'((32'(diff) * 32'(x2_q[25:10])) >> 16);

    s4_q  <= 20'(20'(pm3_q) * 20'(tofc_pkg::Q_LN2) + 20'(lnm3_q) + 20'(tofc_pkg::Q_C091));
    sq5_q <= 24'((40'(s4_q) * 40'(s4_q) + 40'd32768) >> 16);
    sh6_q <= en_q[4] ? 21'((45'(sq5_q) * 45'(tofc_pkg::Q_C017) + 45'd32768) >> 16) : '0;

    for (int k = 4; k <= 6; k++) begin
      a1_q[k] <= a1_q[k-1];
      a2_q[k] <= a2_q[k-1];
    end

    priority if (err_q[5]) begin
      res7_q <= '0;
    end else if (r_d > 52'sd2147483647) begin
      res7_q <= 32'sh7fffffff;
    end else if (r_d < -52'sd2147483648) begin
      res7_q <= 32'sh80000000;
    end else begin
      res7_q <= 32'(r_d);
    end
  end

  assign out_valid_o               = v_q[NS-1];
  assign out_word_o.corrected_time = res7_q;
  assign out_word_o.index_error    = err_q[NS-1];
  assign inflight_o = ($clog2(NS+1))'($countones(v_q));

endmodule

// ===== hdl/tower_time_of_flight_correction.sv =====
// top level of the tower time-of-flight correction block
//
//  channel   | handshake            | word
//  ----------+----------------------+--------------------------------------
//  input     | push / full          | in_word_i  (mode, tower index, time, energy, value)
//  result    | empty / pop          | out_word_o (corrected_time, index_error)
//  config    | cfg_valid_i/ready_o  | cfg_data_i (mean_start_time)
//
//  one word per cycle sustained while results are popped; a correction word reaches the
//  result side through the front lookup, queue, seven-stage back end and output queue
//  table writes are applied in the front end and give no result
//  reset clears control, the sector tables (zero offset, unit gain) and the start time
//  full rises when the queue count plus the word in the front stage reaches the queue
//  depth; empty stalls are absorbed by the output queue, which the back end never overruns
module tower_time_of_flight_correction #(
  parameter int ARMS    = tofc_pkg::ARMS_DEF,
  parameter int SECTORS = tofc_pkg::SECTORS_DEF,
  parameter int ROWS    = tofc_pkg::ROWS_DEF,
  parameter int COLUMNS = tofc_pkg::COLUMNS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  tofc_pkg::in_word_t   in_word_i,
  output logic                 empty,
  input  logic                 pop,
  output tofc_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i
);
  localparam int MID_CW = $clog2(tofc_pkg::MID_DEPTH+1);
  localparam int OUT_CW = $clog2(tofc_pkg::OUT_DEPTH+1);
  localparam int INF_W  = $clog2(tofc_pkg::BACK_STAGES+1);
  localparam int SUM_W  = ((OUT_CW > INF_W) ? OUT_CW : INF_W) + 1;

  // mean start time register
  logic signed [31:0] t0_q;

  // front to back queue
  logic                mid_push, mid_pop, mid_empty, mid_full;
  logic [MID_CW-1:0]   mid_cnt;
  tofc_pkg::mid_word_t mid_in, mid_out;

  // back end to output queue
  logic                back_valid;
  tofc_pkg::out_word_t back_word;
  logic [INF_W-1:0]    inflight;
  logic [OUT_CW-1:0]   out_cnt;
  logic                out_full;
  logic [SUM_W-1:0]    credit_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      t0_q <= cfg_data_i;
    end
  end

  tofc_front #(
    .ARMS      (ARMS),
    .SECTORS   (SECTORS),
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .MID_DEPTH (tofc_pkg::MID_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .mid_cnt_i  (mid_cnt),
    .mid_push_o (mid_push),
    .mid_word_o (mid_in)
  );

  tofc_queue #(
    .DEPTH (tofc_pkg::MID_DEPTH),
    .WIDTH ($bits(tofc_pkg::mid_word_t))
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .count_o (mid_cnt),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  // issue into the back end only with a guaranteed slot in the output queue
  assign credit_sum = SUM_W'(out_cnt) + SUM_W'(inflight);
  assign mid_pop    = !mid_empty && (credit_sum < SUM_W'(tofc_pkg::OUT_DEPTH));

  tofc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (mid_pop),
    .mid_word_i        (mid_out),
    .mean_start_time_i (t0_q),
    .out_valid_o       (back_valid),
    .out_word_o        (back_word),
    .inflight_o        (inflight)
  );

  tofc_queue #(
    .DEPTH (tofc_pkg::OUT_DEPTH),
    .WIDTH ($bits(tofc_pkg::out_word_t))
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  (back_word),
    .pop_i   (pop && !empty),
    .data_o  (out_word_o),
    .count_o (out_cnt),
    .empty_o (empty),
    .full_o  (out_full)
  );

  // the credit schemes must keep both queues from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni) mid_push |-> !mid_full || mid_pop)
    else $error("front pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) back_valid |-> !out_full)
    else $error("back end pushed into a full output queue");

  // an index error always carries a zero time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.index_error) |-> (out_word_o.corrected_time == 32'sd0))
    else $error("index error with nonzero time");

endmodule
